// ===== hw/rtl/wps_pkg.sv =====
// shared constants, types and the arctangent table for the waypoint heading steer block
// no dependencies; every other rtl file imports this package
package wps_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  localparam int unsigned POS_W      = 31;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned HEAD_W     = 16;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned VEC_W      = 43;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned DEG_W      = 17;
  localparam int unsigned DERR_W     = DEG_W + 1;
  localparam int unsigned RANGE_W    = 32;
  localparam int unsigned STEER_W    = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned LOC_W  = 48;
  localparam int unsigned RSUM_W = 59;
  localparam int unsigned SUM_W  = 36;
  localparam int unsigned REM_W  = 18;

  localparam int unsigned DEG_SCALE = 92160;
  localparam int unsigned STEER_MOD = 360;
  localparam logic [31:0] INV_GAIN  = 32'h9B74_EDA8;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam int unsigned ROUND_HALF = 32768;

  // ceil(2^27 / 360): the shifted product gives the exact quotient for dividends below 2^18
  localparam int unsigned REM_SHIFT = 27;
  localparam int unsigned REM_RECIP = ((1 << REM_SHIFT) + STEER_MOD - 1) / STEER_MOD;
  localparam int unsigned QUO_W     = 9;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd128;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd1536;
  localparam logic [GAIN_W-1:0] LOCK_WINDOW_RST = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_DERIV_GAIN  = 2'd1,
    CFG_LOCK_WINDOW = 2'd2
  } cfg_reg_e;

  // what the cordic unit hands back to the sequencer
  typedef struct packed {
    logic                    done;
    logic signed [VEC_W-1:0] x;
    logic [ANG_W-1:0]        z;
  } cordic_res_t;

  // arctangent of 2^-i as a 32 bit binary angle, truncated
  function automatic logic [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517C;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A2F;
      5'd19:   val = 32'h0000_0517;
      5'd20:   val = 32'h0000_028B;
      5'd21:   val = 32'h0000_0145;
      5'd22:   val = 32'h0000_00A2;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/wps_if.sv =====
// valid/ready channel interfaces: pose input, steer result and register writes
// depends on wps_pkg for field widths
interface wps_in_if;
  import wps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic signed [HEAD_W-1:0] pose_heading;
  logic signed [POS_W-1:0] goal_x;
  logic signed [POS_W-1:0] goal_y;

  modport source (output valid, pose_x, pose_y, pose_heading, goal_x, goal_y, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, goal_x, goal_y, output ready);
endinterface

interface wps_out_if;
  import wps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steer_cmd;
  logic signed [DEG_W-1:0]   waypoint_bearing;
  logic [RANGE_W-1:0]        waypoint_range;
  logic                      heading_locked;

  modport source (output valid, steer_cmd, waypoint_bearing, waypoint_range, heading_locked,
                  input ready);
  modport sink   (input valid, steer_cmd, waypoint_bearing, waypoint_range, heading_locked,
                  output ready);
endinterface

interface wps_cfg_if;
  import wps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wps_cordic.sv =====
// iterative cordic vectoring unit: one shift/add micro-rotation per cycle
// depends on wps_pkg (widths, step count, arctangent table)
module wps_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [wps_pkg::DIFF_W-1:0] dx_i,
  input  logic signed [wps_pkg::DIFF_W-1:0] dy_i,
  output wps_pkg::cordic_res_t              res_o
);
  import wps_pkg::*;

  localparam logic [ATAN_IDX_W-1:0] STEP_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

  logic signed [VEC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [VEC_W-1:0] xs, ys, x_ext, y_ext;
  logic [ANG_W-1:0]        z_q, z_d;
  logic [ATAN_IDX_W-1:0]   step_q, step_d;
  logic                    busy_q, busy_d, done_q, done_d;

  assign x_ext = VEC_W'(dx_i) <<< GUARD_BITS;
  assign y_ext = VEC_W'(dy_i) <<< GUARD_BITS;
  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // left half plane: flip the vector and start from a half turn
      if (dx_i < 0) begin
        x_d = -x_ext;
        y_d = -y_ext;
        z_d = HALF_TURN;
      end else begin
        x_d = x_ext;
        y_d = y_ext;
        z_d = '0;
      end
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q < 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_lut(step_q);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_lut(step_q);
      end
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign res_o.done = done_q;
  assign res_o.x    = x_q;
  assign res_o.z    = z_q;

endmodule

// ===== hw/rtl/wps_mul.sv =====
// shared signed multiplier with a registered product
// depends on wps_pkg for operand widths
module wps_mul (
  input  logic                              clk_i,
  input  logic signed [wps_pkg::MUL_W-1:0]  a_i,
  input  logic signed [wps_pkg::MUL_W-1:0]  b_i,
  output logic signed [wps_pkg::PROD_W-1:0] p_o
);
  import wps_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/waypoint_heading_pd_steer.sv =====
// top level of the waypoint heading pd steering controller: sequencer, pd step, remainder
// depends on wps_pkg, wps_if, wps_cordic and wps_mul
//
// One pose/goal item is taken when the block is idle. Its result is built in order: the
// cordic is started from the latched goal offset, runs CORDIC_STEPS (16) micro-rotations
// and hands the vector back; five issues of the shared 33x33 multiplier follow (bearing
// scale, two range partial products, proportional and derivative terms); the terms are
// added and truncated; the remainder by 360 is taken (a reciprocal multiply on the same
// multiplier and a correction); and the output register is loaded. A new item is taken
// only once the block is back in idle. Input ready returns as soon as the result sits in
// the output register, even if it is not yet taken; a stalled result holds the next item
// in its last step. Register writes are accepted every cycle; unknown register indexes
// are dropped.
module waypoint_heading_pd_steer (
  input  logic       clk_i,
  input  logic       rst_ni,
  wps_in_if.sink     in_i,
  wps_out_if.source  out_o,
  wps_cfg_if.sink    cfg_i
);
  import wps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CORDIC,
    ST_MUL_BEAR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_TRUNC,
    ST_REM_MUL,
    ST_REM_FIX,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0]        prop_q, prop_d, deriv_q, deriv_d, lockw_q, lockw_d;
  logic signed [DEG_W-1:0]  prev_q, prev_d;
  logic signed [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [HEAD_W-1:0]        hd_q, hd_d;
  logic                     zero_q, zero_d;
  logic signed [VEC_W-1:0]  xf_q, xf_d;
  logic [ANG_W-1:0]         bs_q, bs_d;
  logic signed [DEG_W-1:0]  bear_q, bear_d;
  logic [LOC_W-1:0]         loc_q, loc_d;
  logic [RANGE_W-1:0]       range_q, range_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic                     neg_q, neg_d;
  logic [REM_W-1:0]         rem_q, rem_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [STEER_W-1:0] steer_q, steer_d;
  logic signed [DEG_W-1:0]   obear_q, obear_d;
  logic [RANGE_W-1:0]        orange_q, orange_d;
  logic                      locked_q, locked_d;

  logic                     cordic_start;
  cordic_res_t              cres;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        bsum;
  logic [RSUM_W-1:0]        rsum;
  logic [RSUM_W-25:0]       rshift;
  logic signed [DERR_W-1:0] derr;
  logic [SUM_W-1:0]         acc_mag;
  logic [QUO_W-1:0]         rem_quo;
  logic [REM_W-1:0]         rem_sub;
  logic [DEG_W-1:0]         bear_mag;

  wps_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .res_o   (cres)
  );

  wps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid            = out_valid_q;
  assign out_o.steer_cmd        = steer_q;
  assign out_o.waypoint_bearing = obear_q;
  assign out_o.waypoint_range   = orange_q;
  assign out_o.heading_locked   = locked_q;

  // round to nearest on the degree scale, ties rounded up toward positive
  assign bsum     = prod + (PROD_W'(1) << 31);
  assign rsum     = prod[RSUM_W-1:0] + RSUM_W'(loc_q[LOC_W-1:16]);
  assign rshift   = rsum[RSUM_W-1:24];
  assign derr     = DERR_W'(bear_q) - DERR_W'(prev_q);
  assign acc_mag  = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  // quotient by 360 from the reciprocal product, then back to a multiple of 360
  assign rem_quo  = prod[REM_SHIFT+QUO_W-1:REM_SHIFT];
  assign rem_sub  = REM_W'(rem_quo) * REM_W'(STEER_MOD);
  assign bear_mag = bear_q[DEG_W-1] ? DEG_W'(-bear_q) : DEG_W'(bear_q);

  always_comb begin
    state_d     = state_q;
    prop_d      = prop_q;
    deriv_d     = deriv_q;
    lockw_d     = lockw_q;
    prev_d      = prev_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    hd_d        = hd_q;
    zero_d      = zero_q;
    xf_d        = xf_q;
    bs_d        = bs_q;
    bear_d      = bear_q;
    loc_d       = loc_q;
    range_d     = range_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    steer_d     = steer_q;
    obear_d     = obear_q;
    orange_d    = orange_q;
    locked_d    = locked_q;
    cordic_start = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PROP_GAIN:   prop_d  = cfg_i.data;
        CFG_DERIV_GAIN:  deriv_d = cfg_i.data;
        CFG_LOCK_WINDOW: lockw_d = cfg_i.data;
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          dx_d    = DIFF_W'(in_i.goal_x) - DIFF_W'(in_i.pose_x);
          dy_d    = DIFF_W'(in_i.goal_y) - DIFF_W'(in_i.pose_y);
          hd_d    = in_i.pose_heading;
          zero_d  = (in_i.goal_x == in_i.pose_x) && (in_i.goal_y == in_i.pose_y);
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cordic_start = 1'b1;
        state_d      = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cres.done) begin
          xf_d    = cres.x;
          bs_d    = cres.z - {hd_q, 16'b0};
          state_d = ST_MUL_BEAR;
        end
      end
      ST_MUL_BEAR: begin
        mul_a   = MUL_W'($signed(bs_q));
        mul_b   = MUL_W'(DEG_SCALE);
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        bear_d  = zero_q ? '0 : $signed(bsum[DEG_W+31:32]);
        mul_a   = MUL_W'(xf_q[15:0]);
        mul_b   = MUL_W'(INV_GAIN);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        loc_d   = prod[LOC_W-1:0];
        mul_a   = MUL_W'(xf_q[VEC_W-2:16]);
        mul_b   = MUL_W'(INV_GAIN);
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        if (zero_q || xf_q <= 0) begin
          range_d = '0;
        end else if (|rshift[RSUM_W-25:RANGE_W]) begin
          range_d = '1;
        end else begin
          range_d = rshift[RANGE_W-1:0];
        end
        mul_a   = MUL_W'(prop_q);
        mul_b   = MUL_W'(bear_q);
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_d   = $signed(prod[SUM_W-1:0]) + SUM_W'(ROUND_HALF);
        mul_a   = MUL_W'(deriv_q);
        mul_b   = MUL_W'(derr);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + $signed(prod[SUM_W-1:0]);
        state_d = ST_TRUNC;
      end
      ST_TRUNC: begin
        // truncate toward zero: work on the magnitude, sign restored at the end
        neg_d   = acc_q[SUM_W-1];
        rem_d   = acc_mag[REM_W+15:16];
        state_d = ST_REM_MUL;
      end
      ST_REM_MUL: begin
        mul_a   = MUL_W'(rem_q);
        mul_b   = MUL_W'(REM_RECIP);
        state_d = ST_REM_FIX;
      end
      ST_REM_FIX: begin
        rem_d   = rem_q - rem_sub;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          steer_d     = neg_q ? -STEER_W'(rem_q) : STEER_W'(rem_q);
          obear_d     = bear_q;
          orange_d    = range_q;
          locked_d    = (bear_mag <= DEG_W'(lockw_q));
          prev_d      = bear_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prop_q      <= PROP_GAIN_RST;
      deriv_q     <= DERIV_GAIN_RST;
      lockw_q     <= LOCK_WINDOW_RST;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prop_q      <= prop_d;
      deriv_q     <= deriv_d;
      lockw_q     <= lockw_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    hd_q     <= hd_d;
    zero_q   <= zero_d;
    xf_q     <= xf_d;
    bs_q     <= bs_d;
    bear_q   <= bear_d;
    loc_q    <= loc_d;
    range_q  <= range_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    steer_q  <= steer_d;
    obear_q  <= obear_d;
    orange_q <= orange_d;
    locked_q <= locked_d;
  end

endmodule

// ===== hw/rtl/wps_check.sv =====
// port-level checks for the waypoint heading steer block, bound to the top level
// depends on wps_pkg for field widths
module wps_check (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [wps_pkg::STEER_W-1:0] steer_cmd_i,
  input logic signed [wps_pkg::DEG_W-1:0]  bearing_i,
  input logic [wps_pkg::RANGE_W-1:0]       range_i,
  input logic                              locked_i
);
  import wps_pkg::*;

  // a transfer in starts a multi-cycle job, so the block goes busy at once
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(steer_cmd_i)
      && $stable(bearing_i) && $stable(range_i) && $stable(locked_i))
    else $error("stalled result dropped or changed");

  a_steer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (steer_cmd_i <= 359) && (steer_cmd_i >= -359))
    else $error("steer command outside the remainder range");

  a_zero_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (bearing_i == '0) |-> locked_i)
    else $error("zero bearing not flagged as locked");

endmodule

bind waypoint_heading_pd_steer wps_check u_wps_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .steer_cmd_i (out_o.steer_cmd),
  .bearing_i   (out_o.waypoint_bearing),
  .range_i     (out_o.waypoint_range),
  .locked_i    (out_o.heading_locked)
);

// ===== test/waypoint_heading_pd_steer_tb.sv =====
// testbench for waypoint_heading_pd_steer: directed and random pose/goal traffic,
// each result checked against an in-bench prediction of bearing, range, lock flag and pd steer
// depends on wps_pkg, the wps_*_if interfaces and the rtl top level
module waypoint_heading_pd_steer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wps_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 64;

  localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED_IDX = 2'd3;
  localparam logic [GAIN_W-1:0]      LOCK_MAX       = 16'd46080;
  localparam logic signed [POS_W-1:0] POS_LO        = 31'sh4000_0000;
  localparam logic signed [POS_W-1:0] POS_HI        = 31'sh3FFF_FFFF;
  localparam logic signed [HEAD_W-1:0] HEAD_LO      = 16'sh8000;
  localparam logic signed [HEAD_W-1:0] HEAD_HI      = 16'sh7FFF;
  localparam longint unsigned RANGE_SCALE           = 64'd2608131496;

  // arctangent of 2^-i, 2^32 per turn, truncated
  localparam logic [31:0] ATAN_TABLE [24] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic signed [HEAD_W-1:0] pose_heading;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
  } pose_item_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer_cmd;
    logic signed [DEG_W-1:0]   waypoint_bearing;
    logic [RANGE_W-1:0]        waypoint_range;
    logic                      heading_locked;
  } steer_result_t;

  logic clk;
  logic rst_n;

  wps_in_if  pose_if ();
  wps_out_if steer_if ();
  wps_cfg_if cfg_if ();

  waypoint_heading_pd_steer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pose_if),
    .out_o  (steer_if),
    .cfg_i  (cfg_if)
  );

  // predictor copy of the registers and the pd memory
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] deriv_gain;
  logic [GAIN_W-1:0] lock_window;
  longint            last_bearing;

  steer_result_t steer_expect_q[$];
  int unsigned   fail_count = 0;
  logic          idle_on = 1'b1;
  logic          sink_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // goal bearing in degrees q8.8 and range q16.16 from one pose item
  function automatic void locate_goal(input pose_item_t p, output longint bearing,
                                      output logic [RANGE_W-1:0] wp_range);
    longint dx, dy, vx, vy, sx, sy, rel_s;
    logic [31:0] ang, rel;
    longint unsigned ux, hi, lo, prod;
    dx = longint'(p.goal_x) - longint'(p.pose_x);
    dy = longint'(p.goal_y) - longint'(p.pose_y);
    bearing = 0;
    wp_range = '0;
    if (dx != 0 || dy != 0) begin
      vx = dx * 256;
      vy = dy * 256;
      ang = '0;
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy < 0) begin
          vx = vx - sy;
          vy = vy + sx;
          ang = ang - ATAN_TABLE[i];
        end else begin
          vx = vx + sy;
          vy = vy - sx;
          ang = ang + ATAN_TABLE[i];
        end
      end
      rel = ang - {p.pose_heading, 16'h0000};
      rel_s = longint'($signed(rel));
      bearing = (rel_s * 92160 + 64'sd2147483648) >>> 32;
      if (vx > 0) begin
        ux = longint'(vx);
        hi = ux >> 16;
        lo = ux & 64'hFFFF;
        prod = (hi * RANGE_SCALE + ((lo * RANGE_SCALE) >> 16)) >> 24;
        wp_range = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
    end
  endfunction

  // expected result of one item; advances the pd memory
  function automatic steer_result_t predict_steer(input pose_item_t p);
    steer_result_t res;
    longint bearing, derr, sum, whole, mag;
    logic [RANGE_W-1:0] wp_range;
    locate_goal(p, bearing, wp_range);
    derr = bearing - last_bearing;
    sum = longint'(prop_gain) * bearing + longint'(deriv_gain) * derr + 32768;
    // truncate toward zero, then remainder keeps the dividend's sign
    whole = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
    mag = (bearing < 0) ? -bearing : bearing;
    last_bearing = bearing;
    res.steer_cmd = STEER_W'(whole % 360);
    res.waypoint_bearing = DEG_W'(bearing);
    res.waypoint_range = wp_range;
    res.heading_locked = (mag <= longint'(lock_window));
    return res;
  endfunction

  function automatic pose_item_t mk_pose(input logic signed [POS_W-1:0] px,
                                         input logic signed [POS_W-1:0] py,
                                         input logic signed [HEAD_W-1:0] hd,
                                         input logic signed [POS_W-1:0] gx,
                                         input logic signed [POS_W-1:0] gy);
    pose_item_t p;
    p.pose_x = px;
    p.pose_y = py;
    p.pose_heading = hd;
    p.goal_x = gx;
    p.goal_y = gy;
    return p;
  endfunction

  function automatic pose_item_t make_random_pose();
    pose_item_t p;
    int kind, d, lat, h, ox, oy;
    kind = $urandom_range(0, 99);
    p.pose_x = POS_W'($urandom());
    p.pose_y = POS_W'($urandom());
    p.pose_heading = HEAD_W'($urandom());
    p.goal_x = POS_W'($urandom());
    p.goal_y = POS_W'($urandom());
    if (kind >= 35) begin
      // keep the vehicle off the edges so the goal offset cannot wrap
      p.pose_x = p.pose_x >>> 2;
      p.pose_y = p.pose_y >>> 2;
      ox = int'($urandom_range(0, 2 << 20)) - (1 << 20);
      oy = int'($urandom_range(0, 2 << 20)) - (1 << 20);
      if (kind < 50) begin
        ox = int'($urandom_range(0, 16)) - 8;
        oy = int'($urandom_range(0, 16)) - 8;
      end else if (kind < 80) begin
        // goal near one of the four axes, heading near a multiple of a quarter turn
        d = $urandom_range(1, 1 << 24);
        lat = int'($urandom_range(0, 2 * (d >> 5))) - (d >> 5);
        h = int'($urandom_range(0, 3) << 14) + int'($urandom_range(0, 128)) - 64;
        p.pose_heading = HEAD_W'(h);
        case (h >>> 14)
          0:       begin ox = d;    oy = lat;  end
          1:       begin ox = lat;  oy = d;    end
          2:       begin ox = -d;   oy = lat;  end
          default: begin ox = lat;  oy = -d;   end
        endcase
      end else if (kind < 90) begin
        d = int'($urandom_range(1, 1 << 24)) * ($urandom_range(0, 1) ? 1 : -1);
        ox = $urandom_range(0, 1) ? d : 0;
        oy = (ox == 0) ? d : 0;
      end
      p.goal_x = POS_W'(p.pose_x + ox);
      p.goal_y = POS_W'(p.pose_y + oy);
    end
    return p;
  endfunction

  task automatic send_pose(input pose_item_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pose_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pose_if.valid        <= 1'b1;
    pose_if.pose_x       <= p.pose_x;
    pose_if.pose_y       <= p.pose_y;
    pose_if.pose_heading <= p.pose_heading;
    pose_if.goal_x       <= p.goal_x;
    pose_if.goal_y       <= p.goal_y;
    do @(posedge clk); while (!pose_if.ready);
    steer_expect_q.push_back(predict_steer(p));
  endtask

  task automatic wait_drained();
    while (steer_expect_q.size() != 0) @(posedge clk);
  endtask

  // leaves valid high so back to back writes need no second assignment in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_PROP_GAIN:   prop_gain = val;
      CFG_DERIV_GAIN:  deriv_gain = val;
      CFG_LOCK_WINDOW: lock_window = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] d,
                           input logic [GAIN_W-1:0] w);
    wait_drained();
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_LOCK_WINDOW, w);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_goal_on_vehicle();
    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST, 16'd0);
    send_pose(mk_pose('0, '0, '0, '0, '0));
    send_pose(mk_pose(POS_HI, POS_LO, HEAD_HI, POS_HI, POS_LO));
    send_pose(mk_pose(31'sd12345, -31'sd777, HEAD_LO, 31'sd12345, -31'sd777));
    pose_if.valid <= 1'b0;
  endtask

  task automatic test_field_extremes();
    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST, LOCK_WINDOW_RST);
    send_pose(mk_pose(POS_LO, POS_LO, '0, POS_HI, POS_HI));
    send_pose(mk_pose(POS_HI, POS_HI, HEAD_LO, POS_LO, POS_LO));
    send_pose(mk_pose(POS_LO, POS_HI, HEAD_HI, POS_HI, POS_LO));
    send_pose(mk_pose(POS_HI, POS_LO, 16'sh4000, POS_LO, POS_HI));
    send_pose(mk_pose('0, POS_LO, 16'sh4000, '0, POS_HI));
    send_pose(mk_pose('0, POS_HI, 16'shC000, '0, POS_LO));
    // negative x with zero y takes the half-turn start
    send_pose(mk_pose(31'sd1, '0, '0, '0, '0));
    send_pose(mk_pose('0, '0, '0, 31'sd1, '0));
    send_pose(mk_pose(31'sd1, 31'sd1, HEAD_HI, '0, '0));
    pose_if.valid <= 1'b0;
  endtask

  task automatic test_lock_window_edge();
    pose_item_t p;
    longint b;
    logic [RANGE_W-1:0] r;
    p = mk_pose('0, '0, '0, 31'sd65536000, 31'sd19660800);
    locate_goal(p, b, r);
    if (b < 0) b = -b;
    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST, GAIN_W'(b));
    send_pose(p);
    pose_if.valid <= 1'b0;
    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST, GAIN_W'(b - 1));
    send_pose(p);
    pose_if.valid <= 1'b0;
  endtask

  // full-scale gains with the goal swinging between just left and just right of behind
  task automatic test_large_gains();
    set_gains(16'hFFFF, 16'hFFFF, LOCK_MAX);
    send_pose(mk_pose('0, '0, '0, -31'sd100000, 31'sd1));
    send_pose(mk_pose('0, '0, '0, -31'sd100000, -31'sd1));
    send_pose(mk_pose('0, '0, '0, -31'sd100000, 31'sd1));
    send_pose(mk_pose('0, '0, HEAD_HI, 31'sd5000, 31'sd3));
    pose_if.valid <= 1'b0;
  endtask

  task automatic test_unknown_register();
    wait_drained();
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    cfg_if.valid <= 1'b0;
    send_pose(mk_pose('0, '0, 16'sh0100, 31'sd40000, -31'sd9000));
    send_pose(mk_pose('0, '0, 16'sh0100, 31'sd40000, 31'sd9000));
    pose_if.valid <= 1'b0;
  endtask

  // output side blocked for a long stretch while poses keep coming
  task automatic test_receiver_hold();
    set_gains(PROP_GAIN_RST, DERIV_GAIN_RST, LOCK_WINDOW_RST);
    sink_hold_req <= 1'b1;
    repeat (12) send_pose(make_random_pose());
    pose_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] d,
                           input logic [GAIN_W-1:0] w, input int unsigned n,
                           input logic with_idle);
    idle_on <= with_idle;
    set_gains(p, d, w);
    repeat (n) send_pose(make_random_pose());
    pose_if.valid <= 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(PROP_GAIN_RST, DERIV_GAIN_RST, LOCK_WINDOW_RST, 250, 1'b1);
    run_phase(16'd0, 16'd0, 16'd0, 200, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, LOCK_MAX, 200, 1'b0);
    run_phase(GAIN_W'($urandom()), GAIN_W'($urandom()),
              GAIN_W'($urandom_range(0, LOCK_MAX)), 250, 1'b1);
    run_phase(16'd256, 16'd0, 16'd2560, 200, 1'b1);
    run_phase(16'd0, 16'd256, LOCK_MAX, 100, 1'b1);
    // closing stretch runs at full rate on both sides
    run_phase(PROP_GAIN_RST, DERIV_GAIN_RST, LOCK_WINDOW_RST, 200, 1'b0);
  endtask

  initial begin : test_sequence
    rst_n = 1'b0;
    pose_if.valid        <= 1'b0;
    pose_if.pose_x       <= '0;
    pose_if.pose_y       <= '0;
    pose_if.pose_heading <= '0;
    pose_if.goal_x       <= '0;
    pose_if.goal_y       <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    prop_gain    = PROP_GAIN_RST;
    deriv_gain   = DERIV_GAIN_RST;
    lock_window  = LOCK_WINDOW_RST;
    last_bearing = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_goal_on_vehicle();
    test_field_extremes();
    test_lock_window_edge();
    test_large_gains();
    test_unknown_register();
    test_receiver_hold();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && steer_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result checker and output-side ready pattern
  initial begin : result_sink
    steer_result_t want;
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    steer_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steer_if.valid && steer_if.ready) begin
        if (steer_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: steer %0d bearing %0d range %0d lock %0b",
                   $time, steer_if.steer_cmd, steer_if.waypoint_bearing,
                   steer_if.waypoint_range, steer_if.heading_locked);
          fail_count++;
        end else begin
          want = steer_expect_q.pop_front();
          if (want.steer_cmd !== steer_if.steer_cmd) begin
            $display("%0t: steer_cmd expected %0d actual %0d", $time, want.steer_cmd,
                     steer_if.steer_cmd);
            fail_count++;
          end
          if (want.waypoint_bearing !== steer_if.waypoint_bearing) begin
            $display("%0t: waypoint_bearing expected %0d actual %0d", $time,
                     want.waypoint_bearing, steer_if.waypoint_bearing);
            fail_count++;
          end
          if (want.waypoint_range !== steer_if.waypoint_range) begin
            $display("%0t: waypoint_range expected %0d actual %0d", $time,
                     want.waypoint_range, steer_if.waypoint_range);
            fail_count++;
          end
          if (want.heading_locked !== steer_if.heading_locked) begin
            $display("%0t: heading_locked expected %0b actual %0b", $time,
                     want.heading_locked, steer_if.heading_locked);
            fail_count++;
          end
        end
      end
      if (sink_hold_req) begin
        sink_hold_req <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        steer_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        steer_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        steer_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        steer_if.ready <= 1'b0;
      end else begin
        steer_if.ready <= 1'b1;
      end
    end
  end

  // ends the run if no transfer happens on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (pose_if.valid && pose_if.ready) || (steer_if.valid && steer_if.ready)
          || (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule
